FILE: src/dcq_pkg.sv
`default_nettype none

package dcq_pkg;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [1:0] TIM_ABS  = 2'd0;
  localparam logic [1:0] TIM_REL  = 2'd1;

  localparam logic STAT_FIRED   = 1'b0;
  localparam logic STAT_DROPPED = 1'b1;

  localparam logic CFG_PERSIST = 1'b0;
  localparam logic CFG_DEFREL  = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [30:0]        current_tick;
    logic signed [31:0] target_tick;
    logic [1:0]         timing;
    logic [15:0]        command_id;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] fired_id;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic add;
    logic step;
    logic keep;
    logic clr_ign;
  } chain_ctrl_t;

endpackage

`default_nettype wire

FILE: src/deadline_command_queue.sv
// deadline command queue
// keeps up to SLOTS pending commands in insertion order, each with a deadline.
// input channel: in_valid_i / in_ready_o carry one in_item_i (add, tick or
// session end). output channel: out_valid_o / out_ready_i carry out_item_o.
// configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 persist_across_loads, 1 default_relative); the user must write it only while
// the block is idle, the block itself does not enforce it. an add writes the tail
// entry when accepted; a full table gives one dropped result on the next cycle.
// a tick or session end with stored entries is accepted, walks the row one entry
// at a time, and closes with a step that hands over the final fired item, if any.
// with an empty table no walk takes place.
// fired items come out of a registered output, the final one with last set;
// the walk holds while a fired entry waits on a full output register.
// a new item is taken only when the walk is done and the output register is
// empty or being read.
// reset empties the table and clears both configuration registers.
`default_nettype none

module deadline_command_queue #(
  parameter int SLOTS = 16,
  parameter int TICK_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dcq_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dcq_pkg::out_item_t     out_item_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic              cfg_data_i
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SW = (TICK_BITS > 33) ? TICK_BITS : 33;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   rem_q, rem_d, len;
  logic               op_tick_q, op_tick_d;
  logic [30:0]        now_q, now_d;
  logic               pend_valid_q, pend_valid_d;
  logic [15:0]        pend_id_q, pend_id_d;
  logic               out_valid_q, out_valid_d;
  dcq_pkg::out_item_t out_q, out_d;
  logic               persist_q, defrel_q;

  dcq_pkg::chain_ctrl_t ctrl;
  logic                 head_persist, head_ignore;
  logic [TICK_BITS-1:0] head_deadline;
  logic [15:0]          head_command;

  logic                    out_free, in_fire, full, rel, add_ignore, fire_head, step_ok;
  logic signed [SW-1:0]    sum, sat, hi, lo, now_in_ext, now_run_ext, head_ext;
  logic signed [TICK_BITS-1:0] head_s;
  logic [TICK_BITS-1:0]    add_deadline;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (len == CNT_W'(SLOTS));

  // deadline of an add, saturated to the tick range
  always_comb begin
    unique case (in_item_i.timing)
      dcq_pkg::TIM_ABS: rel = 1'b0;
      dcq_pkg::TIM_REL: rel = 1'b1;
      default:          rel = defrel_q;
    endcase
  end

  assign hi         = {{(SW - TICK_BITS + 1){1'b0}}, {(TICK_BITS - 1){1'b1}}};
  assign lo         = ~hi;
  assign now_in_ext = SW'({1'b0, in_item_i.current_tick});
  assign sum        = SW'(in_item_i.target_tick) + (rel ? now_in_ext : '0);
  assign sat        = (sum > hi) ? hi : ((sum < lo) ? lo : sum);
  assign add_deadline = sat[TICK_BITS-1:0];
  assign add_ignore   = (now_in_ext >= sat);

  // due check on the head of the row
  assign head_s      = head_deadline;
  assign head_ext    = SW'(head_s);
  assign now_run_ext = SW'({1'b0, now_q});
  assign fire_head   = op_tick_q && (now_run_ext >= head_ext) && !head_ignore;
  assign step_ok     = !fire_head || !pend_valid_q || out_free;

  always_comb begin
    ctrl.add     = in_fire && (in_item_i.cmd == dcq_pkg::CMD_ADD) && !full;
    ctrl.step    = (state_q == ST_RUN) && step_ok;
    ctrl.keep    = op_tick_q ? !fire_head : head_persist;
    ctrl.clr_ign = !op_tick_q;
  end

  dcq_chain #(
    .SLOTS    (SLOTS),
    .TICK_BITS(TICK_BITS)
  ) u_chain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .add_persist_i  (persist_q),
    .add_ignore_i   (add_ignore),
    .add_deadline_i (add_deadline),
    .add_command_i  (in_item_i.command_id),
    .head_persist_o (head_persist),
    .head_ignore_o  (head_ignore),
    .head_deadline_o(head_deadline),
    .head_command_o (head_command),
    .len_o          (len)
  );

  always_comb begin
    state_d      = state_q;
    rem_d        = rem_q;
    op_tick_d    = op_tick_q;
    now_d        = now_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item_i.cmd) inside
            dcq_pkg::CMD_ADD: begin
              if (full) begin
                out_valid_d    = 1'b1;
                out_d.status   = dcq_pkg::STAT_DROPPED;
                out_d.fired_id = in_item_i.command_id;
                out_d.last     = 1'b1;
              end
            end
            dcq_pkg::CMD_TICK, dcq_pkg::CMD_END: begin
              if (len != '0) begin
                state_d   = ST_RUN;
                rem_d     = len;
                op_tick_d = (in_item_i.cmd == dcq_pkg::CMD_TICK);
                now_d     = in_item_i.current_tick;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (step_ok) begin
          rem_d = rem_q - CNT_W'(1);
          if (fire_head) begin
            if (pend_valid_q) begin
              out_valid_d    = 1'b1;
              out_d.status   = dcq_pkg::STAT_FIRED;
              out_d.fired_id = pend_id_q;
              out_d.last     = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = head_command;
          end
          if (rem_q == CNT_W'(1)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.status   = dcq_pkg::STAT_FIRED;
          out_d.fired_id = pend_id_q;
          out_d.last     = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rem_q        <= '0;
      op_tick_q    <= 1'b0;
      now_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_id_q    <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      persist_q    <= 1'b0;
      defrel_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      rem_q        <= rem_d;
      op_tick_q    <= op_tick_d;
      now_q        <= now_d;
      pend_valid_q <= pend_valid_d;
      pend_id_q    <= pend_id_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      if (cfg_we_i && (cfg_idx_i == dcq_pkg::CFG_PERSIST)) begin
        persist_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == dcq_pkg::CFG_DEFREL)) begin
        defrel_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("fired item left pending after walk");

  a_run_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rem_q != '0) && (rem_q <= len))
    else $error("walk count out of range");

  a_drop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_item_i.cmd == dcq_pkg::CMD_ADD) && full) |=>
      out_valid_q && (out_q.status == dcq_pkg::STAT_DROPPED) && out_q.last)
    else $error("full add did not report drop");

  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == dcq_pkg::STAT_DROPPED)) |-> out_q.last)
    else $error("drop result without last");

endmodule

`default_nettype wire

FILE: src/dcq_cell.sv
`default_nettype none

module dcq_cell #(
  parameter int TICK_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_i,
  input  wire logic                 shift_i,
  input  wire logic                 w_persist_i,
  input  wire logic                 w_ignore_i,
  input  wire logic [TICK_BITS-1:0] w_deadline_i,
  input  wire logic [15:0]          w_command_i,
  input  wire logic                 n_persist_i,
  input  wire logic                 n_ignore_i,
  input  wire logic [TICK_BITS-1:0] n_deadline_i,
  input  wire logic [15:0]          n_command_i,
  output logic                      persist_o,
  output logic                      ignore_o,
  output logic [TICK_BITS-1:0]      deadline_o,
  output logic [15:0]               command_o
);

  logic                 persist_q, ignore_q;
  logic [TICK_BITS-1:0] deadline_q;
  logic [15:0]          command_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      persist_q  <= w_persist_i;
      ignore_q   <= w_ignore_i;
      deadline_q <= w_deadline_i;
      command_q  <= w_command_i;
    end else if (shift_i) begin
      persist_q  <= n_persist_i;
      ignore_q   <= n_ignore_i;
      deadline_q <= n_deadline_i;
      command_q  <= n_command_i;
    end
  end

  assign persist_o  = persist_q;
  assign ignore_o   = ignore_q;
  assign deadline_o = deadline_q;
  assign command_o  = command_q;

endmodule

`default_nettype wire

FILE: src/dcq_chain.sv
`default_nettype none

module dcq_chain #(
  parameter int SLOTS = 16,
  parameter int TICK_BITS = 32,
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dcq_pkg::chain_ctrl_t ctrl_i,
  input  wire logic                 add_persist_i,
  input  wire logic                 add_ignore_i,
  input  wire logic [TICK_BITS-1:0] add_deadline_i,
  input  wire logic [15:0]          add_command_i,
  output logic                      head_persist_o,
  output logic                      head_ignore_o,
  output logic [TICK_BITS-1:0]      head_deadline_o,
  output logic [15:0]               head_command_o,
  output logic [CNT_W-1:0]          len_o
);

  logic [CNT_W-1:0]     len_q, len_d, ins_idx;
  logic                 w_persist, w_ignore;
  logic [TICK_BITS-1:0] w_deadline;
  logic [15:0]          w_command;
  logic                 persist_c [SLOTS];
  logic                 ignore_c [SLOTS];
  logic [TICK_BITS-1:0] deadline_c [SLOTS];
  logic [15:0]          command_c [SLOTS];

  // add appends at the tail, a kept head rotates to the end of the live region
  assign ins_idx    = ctrl_i.add ? len_q : len_q - CNT_W'(1);
  assign w_persist  = ctrl_i.add ? add_persist_i : persist_c[0];
  assign w_ignore   = ctrl_i.add ? add_ignore_i : (ignore_c[0] & ~ctrl_i.clr_ign);
  assign w_deadline = ctrl_i.add ? add_deadline_i : deadline_c[0];
  assign w_command  = ctrl_i.add ? add_command_i : command_c[0];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic                 wr, shift, n_persist, n_ignore;
    logic [TICK_BITS-1:0] n_deadline;
    logic [15:0]          n_command;

    assign wr    = (ctrl_i.add || (ctrl_i.step && ctrl_i.keep)) && (CNT_W'(g) == ins_idx);
    assign shift = ctrl_i.step && !wr;

    if (g == SLOTS - 1) begin : g_end
      assign n_persist  = persist_c[g];
      assign n_ignore   = ignore_c[g];
      assign n_deadline = deadline_c[g];
      assign n_command  = command_c[g];
    end else begin : g_mid
      assign n_persist  = persist_c[g+1];
      assign n_ignore   = ignore_c[g+1];
      assign n_deadline = deadline_c[g+1];
      assign n_command  = command_c[g+1];
    end

    dcq_cell #(
      .TICK_BITS(TICK_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .wr_i        (wr),
      .shift_i     (shift),
      .w_persist_i (w_persist),
      .w_ignore_i  (w_ignore),
      .w_deadline_i(w_deadline),
      .w_command_i (w_command),
      .n_persist_i (n_persist),
      .n_ignore_i  (n_ignore),
      .n_deadline_i(n_deadline),
      .n_command_i (n_command),
      .persist_o   (persist_c[g]),
      .ignore_o    (ignore_c[g]),
      .deadline_o  (deadline_c[g]),
      .command_o   (command_c[g])
    );
  end

  always_comb begin
    len_d = len_q;
    if (ctrl_i.add) begin
      len_d = len_q + CNT_W'(1);
    end else if (ctrl_i.step && !ctrl_i.keep) begin
      len_d = len_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign head_persist_o  = persist_c[0];
  assign head_ignore_o   = ignore_c[0];
  assign head_deadline_o = deadline_c[0];
  assign head_command_o  = command_c[0];
  assign len_o           = len_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(SLOTS))
    else $error("entry count above capacity");

  a_no_add_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.add |-> (len_q != CNT_W'(SLOTS)))
    else $error("add into full chain");

  a_no_step_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |-> (len_q != '0) && !ctrl_i.add)
    else $error("step on empty chain");

endmodule

`default_nettype wire
